// File: rtl/pfb_pkg.sv
package pfb_pkg;

    // display geometry
    localparam int DISPLAY_WIDTH  = 192;
    localparam int DISPLAY_HEIGHT = 96;
    localparam int PAGES          = (DISPLAY_HEIGHT + 7) / 8;
    localparam int FB_SIZE        = DISPLAY_WIDTH * PAGES;
    localparam int ADDR_W         = $clog2(FB_SIZE);

    // refresh stream layout
    localparam int HDR_LEN   = 9;
    localparam int HDR_POS_W = $clog2(HDR_LEN);
    localparam int POS_W     = $clog2(FB_SIZE + HDR_LEN);

    // field widths
    localparam int COL_W     = 8;
    localparam int ROW_W     = 7;
    localparam int BYTE_W    = 8;
    localparam int BIT_W     = 3;
    localparam int CFG_IDX_W = 2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_BLIT_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BLIT_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BLIT_INVERT = 2'd2;

    // configuration reset values
    localparam logic [COL_W-1:0] BLIT_WIDTH_RST  = 8'd8;
    localparam logic [ROW_W-1:0] BLIT_HEIGHT_RST = 7'd8;

    // window header bytes
    localparam logic [BYTE_W-1:0] HDR_CMD_MODE   = 8'hF0;
    localparam logic [BYTE_W-1:0] HDR_ARG_MODE   = 8'h10;
    localparam logic [BYTE_W-1:0] HDR_CMD_COL    = 8'h15;
    localparam logic [BYTE_W-1:0] HDR_COL_START  = 8'h00;
    localparam logic [BYTE_W-1:0] HDR_COL_END    = 8'(DISPLAY_WIDTH - 1);
    localparam logic [BYTE_W-1:0] HDR_CMD_PAGE   = 8'h75;
    localparam logic [BYTE_W-1:0] HDR_PAGE_START = 8'h00;
    localparam logic [BYTE_W-1:0] HDR_PAGE_END   = 8'(PAGES - 1);
    localparam logic [BYTE_W-1:0] HDR_CMD_WRITE  = 8'h5C;

    typedef enum logic [1:0] {
        FUNC_PLOT    = 2'd0,
        FUNC_BLIT    = 2'd1,
        FUNC_REFRESH = 2'd2,
        FUNC_NONE    = 2'd3
    } pfb_func_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_PLOT,
        ST_BLIT,
        ST_FETCH,
        ST_OUT
    } pfb_state_t;

    typedef struct packed {
        pfb_func_t          func;
        logic [COL_W-1:0]   pixel_x;
        logic [ROW_W-1:0]   pixel_y;
        logic               pixel_on;
        logic [BYTE_W-1:0]  image_byte;
        logic               blit_start;
    } pfb_req_t;

    typedef struct packed {
        logic [BYTE_W-1:0]  out_byte;
        logic               is_data;
        logic               byte_valid;
        logic               frame_last;
        logic               blit_done;
    } pfb_rsp_t;

    typedef struct packed {
        logic [COL_W-1:0]   width;
        logic [ROW_W-1:0]   height;
        logic               invert;
    } pfb_blit_cfg_t;

    typedef struct packed {
        logic               load;
        logic               step;
    } pfb_blit_ctl_t;

    typedef struct packed {
        logic               valid;
        logic [COL_W:0]     x;
        logic [ROW_W:0]     y;
        logic               on;
    } pfb_pix_t;

    typedef struct packed {
        logic [BYTE_W-1:0]  value;
        logic               is_data;
    } pfb_hdr_t;

    // pixel on the display
    function automatic logic pix_visible(input logic [COL_W:0] x, input logic [ROW_W:0] y);
        return (x < (COL_W + 1)'(DISPLAY_WIDTH)) && (y < (ROW_W + 1)'(DISPLAY_HEIGHT));
    endfunction

    // byte address: column plus page times display width
    function automatic logic [ADDR_W-1:0] pix_addr(input logic [COL_W:0] x,
                                                   input logic [ROW_W:0] y);
        logic [ADDR_W-1:0] base;
        base = ADDR_W'(y >> BIT_W) * ADDR_W'(DISPLAY_WIDTH);
        return base + ADDR_W'(x);
    endfunction

    // window header lookup
    function automatic pfb_hdr_t hdr_lookup(input logic [HDR_POS_W-1:0] pos);
        pfb_hdr_t h;
        unique case (pos)
            4'd0:    h = '{value: HDR_CMD_MODE,   is_data: 1'b0};
            4'd1:    h = '{value: HDR_ARG_MODE,   is_data: 1'b1};
            4'd2:    h = '{value: HDR_CMD_COL,    is_data: 1'b0};
            4'd3:    h = '{value: HDR_COL_START,  is_data: 1'b1};
            4'd4:    h = '{value: HDR_COL_END,    is_data: 1'b1};
            4'd5:    h = '{value: HDR_CMD_PAGE,   is_data: 1'b0};
            4'd6:    h = '{value: HDR_PAGE_START, is_data: 1'b1};
            4'd7:    h = '{value: HDR_PAGE_END,   is_data: 1'b1};
            default: h = '{value: HDR_CMD_WRITE,  is_data: 1'b0};
        endcase
        return h;
    endfunction

endpackage

// File: rtl/pfb_ram.sv
module pfb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // one write port, one registered read port (old data on collision)
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// File: rtl/pfb_blit.sv
module pfb_blit import pfb_pkg::*; (
    input  logic          clk,
    input  logic          rst_n,
    input  pfb_blit_ctl_t ctl,
    input  pfb_req_t      req,
    input  pfb_blit_cfg_t cfg,
    output pfb_pix_t      pix,
    output logic          finish,
    output logic          active
);

    logic [COL_W-1:0]  cursor_col_reg, cursor_col_next;
    logic [ROW_W-1:0]  cursor_row_reg, cursor_row_next;
    logic [COL_W-1:0]  origin_col_reg, origin_col_next;
    logic [ROW_W-1:0]  origin_row_reg, origin_row_next;
    logic              active_reg, active_next;
    logic [BIT_W-1:0]  bit_cnt_reg, bit_cnt_next;
    logic [BYTE_W-1:0] shift_reg, shift_next;

    logic [COL_W-1:0]  col_inc;
    logic [ROW_W-1:0]  row_inc;
    logic              col_wrap;
    logic              row_end;

    // cursor advance, wrapping at the bitmap width
    always_comb
    begin
        col_inc  = cursor_col_reg + 1'b1;
        row_inc  = cursor_row_reg + 1'b1;
        col_wrap = (col_inc == cfg.width);
        row_end  = col_wrap && (row_inc == cfg.height);
    end

    // current pixel of the bitmap byte, msb first
    always_comb
    begin
        pix.valid = ctl.step && active_reg;
        pix.x     = {1'b0, origin_col_reg} + {1'b0, cursor_col_reg};
        pix.y     = {1'b0, origin_row_reg} + {1'b0, cursor_row_reg};
        pix.on    = shift_reg[BYTE_W-1] ^ cfg.invert;
        finish    = !active_reg || (bit_cnt_reg == {BIT_W{1'b1}}) || row_end;
    end

    // load a new byte or step one pixel
    always_comb
    begin
        cursor_col_next = cursor_col_reg;
        cursor_row_next = cursor_row_reg;
        origin_col_next = origin_col_reg;
        origin_row_next = origin_row_reg;
        active_next     = active_reg;
        bit_cnt_next    = bit_cnt_reg;
        shift_next      = shift_reg;
        if (ctl.load)
        begin
            shift_next   = req.image_byte;
            bit_cnt_next = '0;
            if (req.blit_start)
            begin
                origin_col_next = req.pixel_x;
                origin_row_next = req.pixel_y;
                cursor_col_next = '0;
                cursor_row_next = '0;
                active_next     = 1'b1;
            end
        end
        else if (pix.valid)
        begin
            shift_next   = {shift_reg[BYTE_W-2:0], 1'b0};
            bit_cnt_next = bit_cnt_reg + 1'b1;
            if (col_wrap)
            begin
                cursor_col_next = '0;
                cursor_row_next = row_inc;
                if (row_end)
                begin
                    active_next = 1'b0;
                end
            end
            else
            begin
                cursor_col_next = col_inc;
            end
        end
    end

    // cursor and origin state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cursor_col_reg <= '0;
            cursor_row_reg <= '0;
            origin_col_reg <= '0;
            origin_row_reg <= '0;
            active_reg     <= 1'b0;
            bit_cnt_reg    <= '0;
        end
        else
        begin
            cursor_col_reg <= cursor_col_next;
            cursor_row_reg <= cursor_row_next;
            origin_col_reg <= origin_col_next;
            origin_row_reg <= origin_row_next;
            active_reg     <= active_next;
            bit_cnt_reg    <= bit_cnt_next;
        end
    end

    // bitmap byte shifter
    always_ff @(posedge clk)
    begin
        shift_reg <= shift_next;
    end

    assign active = active_reg;

endmodule

// File: rtl/page_framebuffer_blit_refresh.sv
// channel   | direction | handshake              | payload
// ----------+-----------+------------------------+------------------------------
// request   | in        | start & !busy          | req (pfb_req_t)
// result    | out       | done, one cycle        | rsp (pfb_rsp_t)
// config    | in        | cfg_valid & cfg_ready  | cfg_index, cfg_data
//
// a plot or refresh request passes through its work state and the result state
// before the next accept, an unused code through the result state only, and a blit
// request steps the pixels of its bitmap byte, on or off the display: every visible
// pixel is a read-modify-write of the framebuffer ram, one read port, one write port.
// after reset a clearing pass writes the 2304 framebuffer bytes, one per cycle,
// with busy high; config writes are taken at any time (cfg_ready stays high).
// done marks the result for one cycle; the receiver cannot stall it.
module page_framebuffer_blit_refresh import pfb_pkg::*; (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  pfb_req_t             req,
    output logic                 done,
    output pfb_rsp_t             rsp,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [BYTE_W-1:0]    cfg_data
);

    pfb_state_t          state_reg, state_next;
    pfb_req_t            req_reg;
    logic [ADDR_W-1:0]   clr_cnt_reg;
    logic [POS_W-1:0]    refresh_pos_reg;
    logic [COL_W-1:0]    blit_width_reg;
    logic [ROW_W-1:0]    blit_height_reg;
    logic                blit_invert_reg;

    // rmw pipeline stage: read issued, write next cycle
    logic                p_valid_reg;
    logic [ADDR_W-1:0]   p_addr_reg;
    logic [BIT_W-1:0]    p_bit_reg;
    logic                p_on_reg;
    logic                hit_reg;
    logic [BYTE_W-1:0]   hit_data_reg;

    logic                accept;
    pfb_blit_ctl_t       blit_ctl;
    pfb_blit_cfg_t       blit_cfg;
    pfb_pix_t            blit_pix;
    logic                blit_finish;
    logic                blit_active;

    pfb_pix_t            iss;
    logic                iss_ok;
    logic [ADDR_W-1:0]   rd_addr;
    logic [BYTE_W-1:0]   rd_data;
    logic [BYTE_W-1:0]   merged;
    logic [BYTE_W-1:0]   bit_mask;
    logic                wr_en;
    logic [ADDR_W-1:0]   wr_addr;
    logic [BYTE_W-1:0]   wr_data;
    logic                hdr_phase;
    logic                frame_end;
    pfb_hdr_t            hdr;

    assign accept    = start && !busy;
    assign cfg_ready = 1'b1;
    assign blit_cfg  = '{width: blit_width_reg, height: blit_height_reg,
                         invert: blit_invert_reg};

    pfb_blit u_blit (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (blit_ctl),
        .req    (req),
        .cfg    (blit_cfg),
        .pix    (blit_pix),
        .finish (blit_finish),
        .active (blit_active)
    );

    pfb_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (FB_SIZE)
    ) u_frame_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (clr_cnt_reg == ADDR_W'(FB_SIZE - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    unique case (req.func)
                        FUNC_PLOT:    state_next = ST_PLOT;
                        FUNC_BLIT:    state_next = ST_BLIT;
                        FUNC_REFRESH: state_next = ST_FETCH;
                        default:      state_next = ST_OUT;
                    endcase
                end
            end
            ST_PLOT:  state_next = ST_OUT;
            ST_BLIT:
            begin
                if (blit_finish)
                begin
                    state_next = ST_OUT;
                end
            end
            ST_FETCH: state_next = ST_OUT;
            ST_OUT:   state_next = ST_IDLE;
            default:  state_next = ST_CLEAR;
        endcase
    end

    // state outputs: handshake, blit control, pixel issue
    always_comb
    begin
        busy          = (state_reg != ST_IDLE);
        done          = (state_reg == ST_OUT);
        blit_ctl.load = (state_reg == ST_IDLE) && start && (req.func == FUNC_BLIT);
        blit_ctl.step = (state_reg == ST_BLIT);
        iss           = '0;
        unique case (state_reg)
            ST_PLOT:
            begin
                iss.valid = 1'b1;
                iss.x     = {1'b0, req_reg.pixel_x};
                iss.y     = {1'b0, req_reg.pixel_y};
                iss.on    = req_reg.pixel_on;
            end
            ST_BLIT: iss = blit_pix;
            default: iss = '0;
        endcase
    end

    // read address: refresh byte or pixel byte
    always_comb
    begin
        iss_ok = iss.valid && pix_visible(iss.x, iss.y);
        if (state_reg == ST_FETCH)
        begin
            rd_addr = ADDR_W'(refresh_pos_reg - POS_W'(HDR_LEN));
        end
        else
        begin
            rd_addr = pix_addr(iss.x, iss.y);
        end
    end

    // write side: clearing pass or modified byte, with same-cycle forwarding
    always_comb
    begin
        merged   = hit_reg ? hit_data_reg : rd_data;
        bit_mask = BYTE_W'(1) << p_bit_reg;
        wr_en    = 1'b0;
        wr_addr  = p_addr_reg;
        wr_data  = p_on_reg ? (merged & ~bit_mask) : (merged | bit_mask);
        if (state_reg == ST_CLEAR)
        begin
            wr_en   = 1'b1;
            wr_addr = clr_cnt_reg;
            wr_data = '0;
        end
        else if (p_valid_reg)
        begin
            wr_en = 1'b1;
        end
    end

    // result fields
    always_comb
    begin
        hdr_phase = (refresh_pos_reg < POS_W'(HDR_LEN));
        frame_end = (refresh_pos_reg == POS_W'(FB_SIZE + HDR_LEN - 1));
        hdr       = hdr_lookup(refresh_pos_reg[HDR_POS_W-1:0]);
        rsp       = '0;
        rsp.blit_done = !blit_active;
        if (done && (req_reg.func == FUNC_REFRESH))
        begin
            rsp.byte_valid = 1'b1;
            rsp.frame_last = frame_end;
            if (hdr_phase)
            begin
                rsp.out_byte = hdr.value;
                rsp.is_data  = hdr.is_data;
            end
            else
            begin
                rsp.out_byte = merged;
                rsp.is_data  = 1'b1;
            end
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_CLEAR;
            clr_cnt_reg     <= '0;
            refresh_pos_reg <= '0;
            p_valid_reg     <= 1'b0;
            hit_reg         <= 1'b0;
            blit_width_reg  <= BLIT_WIDTH_RST;
            blit_height_reg <= BLIT_HEIGHT_RST;
            blit_invert_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            p_valid_reg <= iss_ok;
            hit_reg     <= wr_en && (wr_addr == rd_addr);
            if (state_reg == ST_CLEAR)
            begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
            if (done && (req_reg.func == FUNC_REFRESH))
            begin
                refresh_pos_reg <= frame_end ? '0 : refresh_pos_reg + 1'b1;
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_BLIT_WIDTH:  blit_width_reg  <= cfg_data[COL_W-1:0];
                    CFG_BLIT_HEIGHT: blit_height_reg <= cfg_data[ROW_W-1:0];
                    CFG_BLIT_INVERT: blit_invert_reg <= cfg_data[0];
                    default:         ;
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg <= req;
        end
        p_addr_reg   <= rd_addr;
        p_bit_reg    <= iss.y[BIT_W-1:0];
        p_on_reg     <= iss.on;
        hit_data_reg <= wr_data;
    end

    // checks
    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe held longer than one cycle");

    a_no_idle_write: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> !wr_en)
        else $error("framebuffer write while idle");

    a_write_source: assert property (@(posedge clk) disable iff (!rst_n)
        p_valid_reg |-> $past(state_reg == ST_PLOT || state_reg == ST_BLIT))
        else $error("pixel write without a pixel read");

    a_refresh_in_result: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.byte_valid |-> done)
        else $error("refresh byte outside the result cycle");

endmodule

// File: test/testbench.sv
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import pfb_pkg::*;

    // register index with no register behind it
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
    localparam int N_PHASES = 9;
    localparam int PHASE_ITEMS = 80;
    localparam int TAIL_ITEMS = 20;

    // one pending request or register write
    typedef struct {
        bit                   is_cfg;
        int unsigned          gap;
        pfb_req_t             req;
        logic [CFG_IDX_W-1:0] index;
        logic [BYTE_W-1:0]    data;
    } pending_op_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 start = 1'b0;
    logic                 busy;
    pfb_req_t             req = '0;
    logic                 done;
    pfb_rsp_t             rsp;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [BYTE_W-1:0]    cfg_data = '0;

    page_framebuffer_blit_refresh uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .req       (req),
        .done      (done),
        .rsp       (rsp),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // shadow copy of the framebuffer, blit cursor and registers
    logic [BYTE_W-1:0] shadow_fb [FB_SIZE];
    logic [COL_W-1:0]  cur_col = '0;
    logic [COL_W-1:0]  org_col = '0;
    logic [COL_W-1:0]  blit_w = BLIT_WIDTH_RST;
    logic [ROW_W-1:0]  cur_row = '0;
    logic [ROW_W-1:0]  org_row = '0;
    logic [ROW_W-1:0]  blit_h = BLIT_HEIGHT_RST;
    logic              blit_inv = 1'b0;
    logic              blit_busy = 1'b0;
    int                refresh_pos = 0;

    pending_op_t op_queue [$];
    pfb_rsp_t    rsp_due [$];
    int          outstanding = 0;
    int          gap_pct = 0;
    int          fail_count = 0;
    int          n_plot = 0;
    int          n_blit = 0;
    int          n_refresh = 0;
    int          n_frames = 0;
    int          n_other = 0;
    int          n_cfg = 0;

    // driver state
    bit          took_req;
    bit          took_cfg;
    bit          go_req;
    bit          go_cfg;
    pending_op_t next_op;

    // clock
    initial
    begin
        forever #1 clk = ~clk;
    end

    // run limit
    initial
    begin
        #2000000;
        $display("page_framebuffer_blit_refresh test failed");
        $finish;
    end

    // one pixel into the shadow framebuffer, off-display pixels dropped
    function automatic void put_pixel(input int x, input int y, input logic on);
        int idx;
        if (x < DISPLAY_WIDTH && y < DISPLAY_HEIGHT)
        begin
            idx = x + (y / 8) * DISPLAY_WIDTH;
            shadow_fb[idx][y % 8] = !on;
        end
    endfunction

    // advance the shadow state by one request and return its response
    function automatic pfb_rsp_t frame_step(input pfb_req_t r);
        pfb_rsp_t o;
        int       j;
        int       idx;
        o = '0;
        case (r.func)
            FUNC_PLOT:
            begin
                put_pixel(int'(r.pixel_x), int'(r.pixel_y), r.pixel_on);
            end
            FUNC_BLIT:
            begin
                if (r.blit_start)
                begin
                    org_col = r.pixel_x;
                    org_row = r.pixel_y;
                    cur_col = '0;
                    cur_row = '0;
                    blit_busy = 1'b1;
                end
                // msb first, stop as soon as the bitmap ends
                for (j = BYTE_W - 1; j >= 0; j--)
                begin
                    if (blit_busy)
                    begin
                        put_pixel(int'(org_col) + int'(cur_col), int'(org_row) + int'(cur_row),
                                  r.image_byte[j] ^ blit_inv);
                        cur_col = cur_col + 1'b1;
                        if (cur_col == blit_w)
                        begin
                            cur_col = '0;
                            cur_row = cur_row + 1'b1;
                            if (cur_row == blit_h)
                                blit_busy = 1'b0;
                        end
                    end
                end
            end
            FUNC_REFRESH:
            begin
                o.byte_valid = 1'b1;
                if (refresh_pos < HDR_LEN)
                begin
                    o.is_data = 1'b1;
                    case (refresh_pos)
                        0:       begin o.out_byte = HDR_CMD_MODE; o.is_data = 1'b0; end
                        1:       o.out_byte = HDR_ARG_MODE;
                        2:       begin o.out_byte = HDR_CMD_COL; o.is_data = 1'b0; end
                        3:       o.out_byte = HDR_COL_START;
                        4:       o.out_byte = HDR_COL_END;
                        5:       begin o.out_byte = HDR_CMD_PAGE; o.is_data = 1'b0; end
                        6:       o.out_byte = HDR_PAGE_START;
                        7:       o.out_byte = HDR_PAGE_END;
                        default: begin o.out_byte = HDR_CMD_WRITE; o.is_data = 1'b0; end
                    endcase
                end
                else
                begin
                    idx = refresh_pos - HDR_LEN;
                    o.out_byte = shadow_fb[idx];
                    o.is_data = 1'b1;
                    o.frame_last = (idx == FB_SIZE - 1);
                end
                refresh_pos = o.frame_last ? 0 : refresh_pos + 1;
            end
            default:
            begin
            end
        endcase
        o.blit_done = !blit_busy;
        return o;
    endfunction

    // driver: presents queued requests and register writes
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
            cfg_valid <= 1'b0;
        end
        else
        begin
            took_req = start && !busy;
            took_cfg = cfg_valid && cfg_ready;
            if (took_req || took_cfg || (!start && !cfg_valid))
            begin
                go_req = 1'b0;
                go_cfg = 1'b0;
                if (op_queue.size() > 0)
                begin
                    if (op_queue[0].gap > 0)
                        op_queue[0].gap--;
                    else if (!op_queue[0].is_cfg)
                    begin
                        next_op = op_queue.pop_front();
                        go_req = 1'b1;
                        req <= next_op.req;
                    end
                    // register writes only once the block has drained
                    else if (!took_req && outstanding == 0)
                    begin
                        next_op = op_queue.pop_front();
                        go_cfg = 1'b1;
                        cfg_index <= next_op.index;
                        cfg_data <= next_op.data;
                    end
                end
                start <= go_req;
                cfg_valid <= go_cfg;
            end
        end
    end

    // monitor: checks responses, then records new requests and writes
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (done)
            begin
                if (rsp_due.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("%t: response with none pending: byte %h data %b valid %b last %b done %b",
                                 $realtime, rsp.out_byte, rsp.is_data, rsp.byte_valid,
                                 rsp.frame_last, rsp.blit_done);
                end
                else if (rsp !== rsp_due[0])
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("%t: mismatch byte %h/%h data %b/%b valid %b/%b last %b/%b done %b/%b (exp/act)",
                                 $realtime, rsp_due[0].out_byte, rsp.out_byte,
                                 rsp_due[0].is_data, rsp.is_data,
                                 rsp_due[0].byte_valid, rsp.byte_valid,
                                 rsp_due[0].frame_last, rsp.frame_last,
                                 rsp_due[0].blit_done, rsp.blit_done);
                    void'(rsp_due.pop_front());
                end
                else
                    void'(rsp_due.pop_front());
            end
            if (cfg_valid && cfg_ready)
            begin
                n_cfg++;
                case (cfg_index)
                    CFG_BLIT_WIDTH:  blit_w = cfg_data;
                    CFG_BLIT_HEIGHT: blit_h = cfg_data[ROW_W-1:0];
                    CFG_BLIT_INVERT: blit_inv = cfg_data[0];
                    default:         ;
                endcase
            end
            if (start && !busy)
            begin
                rsp_due.push_back(frame_step(req));
                case (req.func)
                    FUNC_PLOT:    n_plot++;
                    FUNC_BLIT:    n_blit++;
                    FUNC_REFRESH: n_refresh++;
                    default:      n_other++;
                endcase
                if (rsp_due[$].frame_last)
                    n_frames++;
            end
            outstanding <= rsp_due.size();
        end
    end

    // queue one request, with a random idle burst ahead of it
    task automatic push_req(input pfb_func_t f, input int x, input int y, input bit on,
                            input int img, input bit first);
        pending_op_t op;
        op.is_cfg = 1'b0;
        op.gap = ($urandom_range(0, 99) < gap_pct) ? $urandom_range(1, 13) : 0;
        op.req.func = f;
        op.req.pixel_x = COL_W'(x);
        op.req.pixel_y = ROW_W'(y);
        op.req.pixel_on = on;
        op.req.image_byte = BYTE_W'(img);
        op.req.blit_start = first;
        op.index = '0;
        op.data = '0;
        op_queue.push_back(op);
    endtask

    task automatic push_cfg(input logic [CFG_IDX_W-1:0] index, input int data);
        pending_op_t op;
        op.is_cfg = 1'b1;
        op.gap = 0;
        op.req = '0;
        op.index = index;
        op.data = BYTE_W'(data);
        op_queue.push_back(op);
    endtask

    // mostly on the display, sometimes past the right or bottom edge
    function automatic int rand_col();
        return ($urandom_range(0, 9) == 0) ? $urandom_range(DISPLAY_WIDTH, 255)
                                           : $urandom_range(0, DISPLAY_WIDTH - 1);
    endfunction

    function automatic int rand_row();
        return ($urandom_range(0, 9) == 0) ? $urandom_range(DISPLAY_HEIGHT, 127)
                                           : $urandom_range(0, DISPLAY_HEIGHT - 1);
    endfunction

    // stimulus and end of run
    initial
    begin
        int          phase_w [N_PHASES];
        int          phase_h [N_PHASES];
        bit          phase_inv [N_PHASES];
        int          p;
        int          k;
        int          n;
        int          n_full;
        int          made;
        int          pick;
        int          x0;
        int          y0;
        byte         bitmap [8];

        phase_w = '{8, 1, 192, 1, 0, 1, 13, 5, 24};
        phase_h = '{8, 1, 2, 96, 1, 0, 7, 3, 16};
        phase_inv = '{0, 1, 0, 1, 0, 1, 1, 0, 0};
        bitmap = '{8'hFF, 8'h00, 8'hA5, 8'h5A, 8'hFF, 8'h81, 8'h7E, 8'hC3};
        foreach (shadow_fb[i])
            shadow_fb[i] = '0;

        // directed: corners, clipping, unused code, stray and finished blits
        gap_pct = 0;
        push_cfg(CFG_SPARE, 8'hFF);
        push_req(FUNC_REFRESH, 0, 0, 1'b0, 0, 1'b0);
        push_req(FUNC_PLOT, 0, 0, 1'b0, 0, 1'b0);
        push_req(FUNC_PLOT, DISPLAY_WIDTH - 1, DISPLAY_HEIGHT - 1, 1'b0, 0, 1'b0);
        push_req(FUNC_PLOT, DISPLAY_WIDTH - 1, 0, 1'b0, 0, 1'b0);
        push_req(FUNC_PLOT, 0, DISPLAY_HEIGHT - 1, 1'b0, 0, 1'b0);
        push_req(FUNC_PLOT, 255, 127, 1'b0, 0, 1'b0);
        push_req(FUNC_PLOT, DISPLAY_WIDTH, 5, 1'b0, 0, 1'b0);
        push_req(FUNC_PLOT, 5, DISPLAY_HEIGHT, 1'b0, 0, 1'b0);
        push_req(FUNC_PLOT, 0, 0, 1'b1, 0, 1'b0);
        push_req(FUNC_NONE, 255, 127, 1'b1, 255, 1'b1);
        push_req(FUNC_BLIT, 3, 3, 1'b0, 8'hFF, 1'b0);
        // 8x8 bitmap straddling the bottom right corner
        for (k = 0; k < 8; k++)
            push_req(FUNC_BLIT, DISPLAY_WIDTH - 4, DISPLAY_HEIGHT - 4, 1'b0, bitmap[k], k == 0);
        push_req(FUNC_BLIT, 0, 0, 1'b0, 8'hFF, 1'b0);
        for (k = 0; k < 3; k++)
            push_req(FUNC_REFRESH, 0, 0, 1'b0, 0, 1'b0);

        // random phases, one blit setting each; phases 1, 4, 7 and the last one run without idling
        for (p = 0; p < N_PHASES; p++)
        begin
            gap_pct = (p % 3 == 1 || p == N_PHASES - 1) ? 0 : 35;
            push_cfg(CFG_BLIT_WIDTH, phase_w[p]);
            push_cfg(CFG_BLIT_HEIGHT, ($urandom_range(0, 1) << 7) | phase_h[p]);
            push_cfg(CFG_BLIT_INVERT, ($urandom_range(0, 127) << 1) | phase_inv[p]);
            n_full = ((phase_w[p] == 0 ? 256 : phase_w[p]) *
                      (phase_h[p] == 0 ? 128 : phase_h[p]) + 7) / 8;
            made = 0;
            while (made < PHASE_ITEMS)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 45)
                begin
                    // whole bitmap, sometimes cut short or with trailing bytes
                    n = n_full;
                    if (pick < 6)
                        n = $urandom_range(1, n_full);
                    else if (pick < 12)
                        n = n_full + $urandom_range(1, 2);
                    x0 = rand_col();
                    y0 = rand_row();
                    for (k = 0; k < n; k++)
                        push_req(FUNC_BLIT, (k == 0) ? x0 : $urandom_range(0, 255),
                                 (k == 0) ? y0 : $urandom_range(0, 127),
                                 $urandom_range(0, 1), $urandom_range(0, 255), k == 0);
                    made += n;
                end
                else
                begin
                    if (pick < 75)
                        push_req(FUNC_PLOT, rand_col(), rand_row(), $urandom_range(0, 1),
                                 $urandom_range(0, 255), $urandom_range(0, 1));
                    else if (pick < 92)
                        push_req(FUNC_REFRESH, $urandom_range(0, 255), $urandom_range(0, 127),
                                 $urandom_range(0, 1), $urandom_range(0, 255),
                                 $urandom_range(0, 1));
                    else if (pick < 95)
                        push_req(FUNC_NONE, $urandom_range(0, 255), $urandom_range(0, 127),
                                 $urandom_range(0, 1), $urandom_range(0, 255),
                                 $urandom_range(0, 1));
                    else
                        push_req(FUNC_BLIT, $urandom_range(0, 255), $urandom_range(0, 127),
                                 $urandom_range(0, 1), $urandom_range(0, 255), 1'b0);
                    made++;
                end
            end
        end

        // back to back refresh bytes to close the run
        gap_pct = 0;
        for (k = 0; k < TAIL_ITEMS; k++)
            push_req(FUNC_REFRESH, $urandom_range(0, 255), $urandom_range(0, 127),
                     $urandom_range(0, 1), $urandom_range(0, 255), $urandom_range(0, 1));

        // reset, then let the driver run dry
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        while (op_queue.size() != 0 || start || cfg_valid || outstanding != 0)
            @(negedge clk);
        repeat (20) @(negedge clk);

        if (rsp_due.size() != 0)
        begin
            fail_count += rsp_due.size();
            $display("%0d responses never arrived", rsp_due.size());
        end
        $display("requests: %0d plot, %0d blit byte, %0d refresh, %0d unused code",
                 n_plot, n_blit, n_refresh, n_other);
        $display("%0d register writes over %0d blit settings, %0d full frames read back",
                 n_cfg, N_PHASES, n_frames);
        if (fail_count == 0)
            $display("page_framebuffer_blit_refresh test passed");
        else
            $display("page_framebuffer_blit_refresh test failed");
        $finish;
    end

endmodule
